@@ sv/two_link_leg_inverse_kinematics_assert.svh @@
// Assertion macros for the two-link leg inverse kinematics block
`ifndef TWO_LINK_LEG_INVERSE_KINEMATICS_ASSERT_SVH
`define TWO_LINK_LEG_INVERSE_KINEMATICS_ASSERT_SVH
`ifndef SYNTHESIS
`define IKL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ikl assertion failed");
`define IKL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ikl assertion failed");
`else
`define IKL_ASSERT(lbl, prop)
`define IKL_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ sv/ikl_pkg.sv @@
// Shared constants and types of the leg inverse kinematics datapath
package ikl_pkg;
  localparam int unsigned LW = 14;
  localparam int unsigned SQW = 2 * LW;
  localparam int unsigned SQRT_W = 30;
  localparam int unsigned SQRT_LAT = SQRT_W / 2;
  localparam int unsigned NUMW = 31;
  localparam int unsigned DENW = 30;
  localparam int unsigned QFW = 14;
  localparam int unsigned DIV_LAT = QFW + 2;
  localparam int unsigned CW = 35;
  localparam int unsigned AW = 20;
  localparam int unsigned ITERS = 16;
  localparam int unsigned CORDIC_LAT = ITERS + 1;
  localparam logic signed [AW-1:0] ANG_PI = 20'sd205887;
  localparam logic signed [AW-1:0] ANG_HALF_PI = 20'sd102944;
  localparam logic signed [AW-1:0] ATAN_TAB [ITERS] = '{
    20'sd51472, 20'sd30385, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
    20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32, 20'sd16,
    20'sd8, 20'sd4, 20'sd2
  };
  localparam logic [LW-1:0] THIGH_RST = 14'd3424;
  localparam logic [LW-1:0] SHANK_RST = 14'd3195;
  localparam logic [LW-1:0] MIN_RST = 14'd983;
  localparam logic [LW-1:0] MAX_RST = 14'd6226;

  typedef enum logic [1:0] {
    REG_THIGH = 2'd0,
    REG_SHANK = 2'd1,
    REG_MIN   = 2'd2,
    REG_MAX   = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    RSEL_ROOT = 2'd0,
    RSEL_MAX  = 2'd1,
    RSEL_MIN  = 2'd2
  } rsel_e;
endpackage

@@ sv/ikl_delay.sv @@
// Enabled shift line that delays a word through a chain of D registers
module ikl_delay #(
  parameter int unsigned W = 1,
  parameter int unsigned D = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);
  logic [W-1:0] tap_q [D];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < D; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign q_o = tap_q[D-1];
endmodule

@@ sv/ikl_sqrt.sv @@
// Pipelined integer square root, one result bit per cell
module ikl_sqrt #(
  parameter int unsigned W = 30
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [W-1:0]     d_i,
  output logic [W/2-1:0]   root_o
);
  localparam int unsigned N = W / 2;
  localparam int unsigned RW = N + 4;

  logic [W-1:0]  v_q    [N];
  logic [RW-1:0] rem_q  [N];
  logic [N-1:0]  root_q [N];

  for (genvar g = 0; g < N; g++) begin : g_cell
    logic [W-1:0]  v_in;
    logic [RW-1:0] rem_in, rem_sh, trial, rem_d;
    logic [N-1:0]  root_in;
    logic          ge;

    if (g == 0) begin : g_first
      assign v_in    = d_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = v_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
    end

    assign rem_sh = {rem_in[RW-3:0], v_in[W-1:W-2]};
    assign trial  = {2'b00, root_in, 2'b01};
    assign ge     = (rem_sh >= trial);
    assign rem_d  = ge ? (rem_sh - trial) : rem_sh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[g]    <= {v_in[W-3:0], 2'b00};
        rem_q[g]  <= rem_d;
        root_q[g] <= {root_in[N-2:0], ge};
      end
    end
  end

  assign root_o = root_q[N-1];
endmodule

@@ sv/ikl_div.sv @@
// Pipelined Q14 cosine divider with saturation, one quotient bit per cell
module ikl_div (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [ikl_pkg::NUMW-1:0] num_i,
  input  logic [ikl_pkg::DENW-1:0]      den_i,
  output logic signed [15:0]            q_o
);
  localparam int unsigned DW = ikl_pkg::DENW;
  localparam int unsigned QF = ikl_pkg::QFW;

  logic [DW:0]   rem_q  [QF+1];
  logic [DW-1:0] den_q  [QF+1];
  logic [QF-1:0] quo_q  [QF+1];
  logic [QF:0]   sat_q, zero_q, neg_q;
  logic signed [15:0] q_q;

  logic [ikl_pkg::NUMW-1:0] mag_full;
  logic [DW-1:0]            mag;

  assign mag_full = num_i[ikl_pkg::NUMW-1] ? (-num_i) : num_i;
  assign mag      = mag_full[DW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= {1'b0, mag};
      den_q[0]  <= den_i;
      quo_q[0]  <= '0;
      sat_q[0]  <= (mag >= den_i);
      zero_q[0] <= (mag == '0);
      neg_q[0]  <= num_i[ikl_pkg::NUMW-1];
    end
  end

  for (genvar g = 1; g <= QF; g++) begin : g_cell
    logic [DW:0] rem_sh;
    logic        ge;

    assign rem_sh = {rem_q[g-1][DW-1:0], 1'b0};
    assign ge     = (rem_sh >= {1'b0, den_q[g-1]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= ge ? (rem_sh - {1'b0, den_q[g-1]}) : rem_sh;
        den_q[g]  <= den_q[g-1];
        quo_q[g]  <= {quo_q[g-1][QF-2:0], ge};
        sat_q[g]  <= sat_q[g-1];
        zero_q[g] <= zero_q[g-1];
        neg_q[g]  <= neg_q[g-1];
      end
    end
  end

  logic [15:0] qmag;

  always_comb begin
    if (sat_q[QF]) begin
      qmag = zero_q[QF] ? 16'd0 : 16'd16384;
    end else begin
      qmag = {2'b00, quo_q[QF]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q <= neg_q[QF] ? (-$signed(qmag)) : $signed(qmag);
    end
  end

  assign q_o = q_q;
endmodule

@@ sv/ikl_cordic.sv @@
// Pipelined vectoring CORDIC atan2, one rotation per cell
module ikl_cordic (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [16:0]           y_i,
  input  logic signed [16:0]           x_i,
  output logic signed [ikl_pkg::AW-1:0] ang_o
);
  localparam int unsigned CW = ikl_pkg::CW;
  localparam int unsigned N  = ikl_pkg::ITERS;

  logic signed [CW-1:0]          x_q   [N+1];
  logic signed [CW-1:0]          y_q   [N+1];
  logic signed [ikl_pkg::AW-1:0] acc_q [N+1];
  logic [N:0]                    zero_q;

  logic signed [CW-1:0] xe, ye;

  assign xe = {{2{x_i[16]}}, x_i, 16'h0000};
  assign ye = {{2{y_i[16]}}, y_i, 16'h0000};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      if (x_i[16]) begin
        if (!y_i[16]) begin
          x_q[0]   <= ye;
          y_q[0]   <= -xe;
          acc_q[0] <= ikl_pkg::ANG_HALF_PI;
        end else begin
          x_q[0]   <= -ye;
          y_q[0]   <= xe;
          acc_q[0] <= -ikl_pkg::ANG_HALF_PI;
        end
      end else begin
        x_q[0]   <= xe;
        y_q[0]   <= ye;
        acc_q[0] <= '0;
      end
    end
  end

  for (genvar g = 1; g <= N; g++) begin : g_cell
    logic signed [CW-1:0] xs, ys;
    logic                 pos;

    assign xs  = x_q[g-1] >>> (g - 1);
    assign ys  = y_q[g-1] >>> (g - 1);
    assign pos = (y_q[g-1] > 0);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[g] <= zero_q[g-1];
        if (pos) begin
          x_q[g]   <= x_q[g-1] + ys;
          y_q[g]   <= y_q[g-1] - xs;
          acc_q[g] <= acc_q[g-1] + ikl_pkg::ATAN_TAB[g-1];
        end else begin
          x_q[g]   <= x_q[g-1] - ys;
          y_q[g]   <= y_q[g-1] + xs;
          acc_q[g] <= acc_q[g-1] - ikl_pkg::ATAN_TAB[g-1];
        end
      end
    end
  end

  assign ang_o = zero_q[N] ? '0 : acc_q[N];
endmodule

@@ sv/two_link_leg_inverse_kinematics.sv @@
// Top level of the two-link leg inverse kinematics pipeline
//
// Input stream: s_axis_tdata carries foot_x and foot_z; one transfer is one
// foot position. Output stream: m_axis_tdata carries hip_angle and knee_angle,
// m_axis_tuser carries reach_clamped. Every input transfer yields one output
// transfer, in order.
// Configuration: cfg_index_i selects thigh_length, shank_length, min_reach or
// max_reach; cfg_data_i is written on each cfg_valid_i (cfg_ready_o is always
// high). Write only while the pipeline is empty.
// One item enters per cycle while the output is not stalled. The chain of
// cells runs through two root units of 15 cells, the divider of 16 and the
// CORDIC of 17, plus the stages of squaring, clamp select, cosine setup and
// rounding.
// Reset clears the valid bits of every stage and loads the link and reach
// registers with their defaults.
// When the receiver stalls a held result, the whole chain holds and
// s_axis_tready drops until the result is taken.
`include "two_link_leg_inverse_kinematics_assert.svh"
module two_link_leg_inverse_kinematics (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // foot_x[14:0], foot_z[29:15], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // hip_angle[15:0], knee_angle[31:16]
  output logic        m_axis_tuser,   // reach_clamped[0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [13:0] cfg_data_i
);
  localparam int unsigned LW  = ikl_pkg::LW;
  localparam int unsigned SQW = ikl_pkg::SQW;
  localparam int unsigned AW  = ikl_pkg::AW;
  localparam int unsigned RTW = ikl_pkg::SQRT_W / 2;
  localparam int unsigned NST = 2 + ikl_pkg::SQRT_LAT + 1 + ikl_pkg::DIV_LAT + 2
                              + ikl_pkg::SQRT_LAT + ikl_pkg::CORDIC_LAT + 1;
  localparam int unsigned S_DIV = 3 + ikl_pkg::SQRT_LAT + ikl_pkg::DIV_LAT;
  localparam int unsigned XZ_DLY = 1 + ikl_pkg::SQRT_LAT + 1 + ikl_pkg::DIV_LAT + 2
                                 + ikl_pkg::SQRT_LAT;
  localparam int unsigned FL_DLY = ikl_pkg::DIV_LAT + 2 + ikl_pkg::SQRT_LAT
                                 + ikl_pkg::CORDIC_LAT;
  localparam logic [SQW:0] Q28_ONE = 29'h1000_0000;

  logic [LW-1:0] thigh_q, shank_q, min_q, max_q;
  logic [SQW-1:0] l1sq_q, l2sq_q, min2_q, max2_q, l1l2_q;
  logic [NST:1] vld_q;
  logic adv;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thigh_q <= ikl_pkg::THIGH_RST;
      shank_q <= ikl_pkg::SHANK_RST;
      min_q   <= ikl_pkg::MIN_RST;
      max_q   <= ikl_pkg::MAX_RST;
    end else if (cfg_valid_i) begin
      unique case (ikl_pkg::reg_idx_e'(cfg_index_i))
        ikl_pkg::REG_THIGH: thigh_q <= cfg_data_i;
        ikl_pkg::REG_SHANK: shank_q <= cfg_data_i;
        ikl_pkg::REG_MIN:   min_q   <= cfg_data_i;
        ikl_pkg::REG_MAX:   max_q   <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    l1sq_q <= thigh_q * thigh_q;
    l2sq_q <= shank_q * shank_q;
    min2_q <= min_q * min_q;
    max2_q <= max_q * max_q;
    l1l2_q <= thigh_q * shank_q;
  end

  assign adv           = !vld_q[NST] || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-1:1], s_axis_tvalid};
    end
  end

  // square and sum
  logic signed [14:0] x_in, z_in, x1_q, z1_q;
  logic signed [29:0] xx_full, zz_full;
  logic [SQW:0]       xx1_q, zz1_q;
  logic [29:0]        s2_q;

  assign x_in    = s_axis_tdata[14:0];
  assign z_in    = s_axis_tdata[29:15];
  assign xx_full = x_in * x_in;
  assign zz_full = z_in * z_in;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x1_q  <= x_in;
      z1_q  <= z_in;
      xx1_q <= xx_full[SQW:0];
      zz1_q <= zz_full[SQW:0];
      s2_q  <= {1'b0, xx1_q} + {1'b0, zz1_q};
    end
  end

  // reach clamp
  logic               flag3_q;
  ikl_pkg::rsel_e     sel3_q;
  logic [SQW-1:0]     r23_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (s2_q > {2'b00, max2_q}) begin
        flag3_q <= 1'b1;
        sel3_q  <= ikl_pkg::RSEL_MAX;
        r23_q   <= max2_q;
      end else if (s2_q < {2'b00, min2_q}) begin
        flag3_q <= 1'b1;
        sel3_q  <= ikl_pkg::RSEL_MIN;
        r23_q   <= min2_q;
      end else begin
        flag3_q <= 1'b0;
        sel3_q  <= ikl_pkg::RSEL_ROOT;
        r23_q   <= s2_q[SQW-1:0];
      end
    end
  end

  logic [RTW-1:0] root_r;
  logic [SQW+2:0] clamp_d;

  ikl_sqrt #(.W(ikl_pkg::SQRT_W)) u_sqrt_reach (
    .clk_i  (clk_i),
    .en_i   (adv),
    .d_i    (s2_q),
    .root_o (root_r)
  );

  ikl_delay #(.W(SQW + 3), .D(ikl_pkg::SQRT_LAT - 1)) u_dly_clamp (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   ({flag3_q, sel3_q, r23_q}),
    .q_o   (clamp_d)
  );

  // cosine numerators and denominators
  logic [RTW-1:0]     r_sel;
  logic [SQW-1:0]     r2_d;
  logic [SQW:0]       l1r;
  logic signed [ikl_pkg::NUMW-1:0] num_h18_q, num_k18_q;
  logic [ikl_pkg::DENW-1:0]        den_h18_q, den_k18_q;
  logic               flag18_q;

  assign r2_d = clamp_d[SQW-1:0];

  always_comb begin
    unique case (ikl_pkg::rsel_e'(clamp_d[SQW+1:SQW]))
      ikl_pkg::RSEL_MAX:  r_sel = {1'b0, max_q};
      ikl_pkg::RSEL_MIN:  r_sel = {1'b0, min_q};
      default:            r_sel = root_r;
    endcase
  end

  assign l1r = thigh_q * r_sel;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      flag18_q  <= clamp_d[SQW+2];
      den_h18_q <= {l1r, 1'b0};
      den_k18_q <= {1'b0, l1l2_q, 1'b0};
      num_h18_q <= $signed({3'b000, l1sq_q}) + $signed({3'b000, r2_d})
                 - $signed({3'b000, l2sq_q});
      num_k18_q <= $signed({3'b000, l1sq_q}) + $signed({3'b000, l2sq_q})
                 - $signed({3'b000, r2_d});
    end
  end

  logic signed [15:0] c_h, c_k;

  ikl_div u_div_hip (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (num_h18_q),
    .den_i (den_h18_q),
    .q_o   (c_h)
  );

  ikl_div u_div_knee (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (num_k18_q),
    .den_i (den_k18_q),
    .q_o   (c_k)
  );

  // sine side of the arccosines
  logic signed [31:0] csq_h_full, csq_k_full;
  logic signed [15:0] c_h35_q, c_k35_q, c_h36_q, c_k36_q, c_h_d, c_k_d;
  logic [SQW:0]       csq_h_q, csq_k_q, arg_h_q, arg_k_q;
  logic [RTW-1:0]     sin_h, sin_k;

  assign csq_h_full = c_h * c_h;
  assign csq_k_full = c_k * c_k;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_h35_q <= c_h;
      c_k35_q <= c_k;
      csq_h_q <= csq_h_full[SQW:0];
      csq_k_q <= csq_k_full[SQW:0];
      c_h36_q <= c_h35_q;
      c_k36_q <= c_k35_q;
      arg_h_q <= Q28_ONE - csq_h_q;
      arg_k_q <= Q28_ONE - csq_k_q;
    end
  end

  ikl_sqrt #(.W(ikl_pkg::SQRT_W)) u_sqrt_hip (
    .clk_i  (clk_i),
    .en_i   (adv),
    .d_i    ({1'b0, arg_h_q}),
    .root_o (sin_h)
  );

  ikl_sqrt #(.W(ikl_pkg::SQRT_W)) u_sqrt_knee (
    .clk_i  (clk_i),
    .en_i   (adv),
    .d_i    ({1'b0, arg_k_q}),
    .root_o (sin_k)
  );

  ikl_delay #(.W(32), .D(ikl_pkg::SQRT_LAT)) u_dly_cos (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   ({c_h36_q, c_k36_q}),
    .q_o   ({c_h_d, c_k_d})
  );

  // foot direction and clamp flag alignment
  logic signed [16:0] nz1;
  logic signed [14:0] x_d;
  logic signed [16:0] nz_d;
  logic               flag_d;

  assign nz1 = -{{2{z1_q[14]}}, z1_q};

  ikl_delay #(.W(32), .D(XZ_DLY)) u_dly_xz (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   ({x1_q, nz1}),
    .q_o   ({x_d, nz_d})
  );

  ikl_delay #(.W(1), .D(FL_DLY)) u_dly_flag (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   (flag18_q),
    .q_o   (flag_d)
  );

  logic signed [AW-1:0] a_dir, a_hip, a_knee;

  ikl_cordic u_cordic_dir (
    .clk_i (clk_i),
    .en_i  (adv),
    .y_i   ({{2{x_d[14]}}, x_d}),
    .x_i   (nz_d),
    .ang_o (a_dir)
  );

  ikl_cordic u_cordic_hip (
    .clk_i (clk_i),
    .en_i  (adv),
    .y_i   ({2'b00, sin_h}),
    .x_i   ({c_h_d[15], c_h_d}),
    .ang_o (a_hip)
  );

  ikl_cordic u_cordic_knee (
    .clk_i (clk_i),
    .en_i  (adv),
    .y_i   ({2'b00, sin_k}),
    .x_i   ({c_k_d[15], c_k_d}),
    .ang_o (a_knee)
  );

  // round to output units
  logic signed [AW:0] hip_sum, knee_sum;
  logic [15:0]        hip_q, knee_q;
  logic               flag_q;

  assign hip_sum  = {a_dir[AW-1], a_dir} - {a_hip[AW-1], a_hip} + 21'sd8;
  assign knee_sum = {ikl_pkg::ANG_PI[AW-1], ikl_pkg::ANG_PI}
                  - {a_knee[AW-1], a_knee} + 21'sd8;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hip_q  <= hip_sum[19:4];
      knee_q <= knee_sum[19:4];
      flag_q <= flag_d;
    end
  end

  assign m_axis_tvalid = vld_q[NST];
  assign m_axis_tdata  = {knee_q, hip_q};
  assign m_axis_tuser  = flag_q;

  `IKL_ASSERT(a_clamp_value, !(vld_q[3] && flag3_q) || (r23_q == max2_q || r23_q == min2_q))
  `IKL_ASSERT(a_cos_range, !vld_q[S_DIV] ||
      (c_h <= 16'sd16384 && c_h >= -16'sd16384 &&
       c_k <= 16'sd16384 && c_k >= -16'sd16384))
  `IKL_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, $stable(vld_q))
endmodule
